// ===== design/bmh_pkg.sv =====
// Package for the binary min-heap: payload structs, status and mode codes,
// and the controller/datapath command and status structs. No dependencies.
package bmh_pkg;

   localparam int unsigned DEF_CAPACITY = 64;
   localparam int unsigned KEY_W        = 32;
   localparam int unsigned POS_W        = 6;
   localparam int unsigned COUNT_W      = 7;

   localparam logic [1:0] MODE_INSERT   = 2'd0;
   localparam logic [1:0] MODE_DECREASE = 2'd1;
   localparam logic [1:0] MODE_SINK     = 2'd2;
   localparam logic [1:0] MODE_NONE     = 2'd3;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_FULL        = 2'd1;
   localparam logic [1:0] ST_NOT_LIVE    = 2'd2;
   localparam logic [1:0] ST_NOT_LOWERED = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [KEY_W-1:0]   entry_key;
      logic signed [31:0] entry_value;
      logic [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [KEY_W-1:0]   top_key;
      logic signed [31:0] top_value;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;      // capture request, set index
      logic       start;     // take the moving entry into the hold register
      logic       grow;      // count one more live entry
      logic       rd_par;    // read parent of index
      logic       move_up;   // drop parent into index, climb to parent
      logic       rd_left;   // read left child of index
      logic       rd_right;  // keep left child, read right child
      logic       move_down; // lift smaller child into index, descend to it
      logic       place;     // write the held entry at index
      logic       rd_top;    // read root
      logic       finish;    // load response register
      logic [1:0] status;    // status to report
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] mode;
      logic       full;
      logic       not_live;
      logic       not_lowered;
      logic       at_root;    // index is the root
      logic       up_move;    // held key below parent key
      logic       has_left;   // index has a live left child
      logic       down_move;  // smaller live child below held key
   } sts_type;

endpackage

// ===== design/bmh_datapath.sv =====
// Datapath for the binary min-heap: key/value memory, index and hold
// registers, child/parent compares and response register. Depends on bmh_pkg.
module bmh_datapath #(
   parameter int unsigned CAPACITY = bmh_pkg::DEF_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  bmh_pkg::req_type  req_in,
   input  bmh_pkg::cmd_type  cmd,
   output bmh_pkg::sts_type  sts,
   output bmh_pkg::rsp_type  rsp_out
);
   import bmh_pkg::*;

   localparam int unsigned AW  = $clog2(CAPACITY);
   localparam int unsigned CW  = $clog2(CAPACITY + 1);
   localparam int unsigned CIW = AW + 2;
   localparam int unsigned PW  = (POS_W > CW) ? POS_W : CW;

   // key in the upper half, value in the lower half; one read, one write a cycle
   logic [63:0]    mem [CAPACITY];

   req_type        req_ff;
   logic [CW-1:0]  count_ff;
   logic [AW-1:0]  idx_ff;
   logic [63:0]    rd_ff, cur_ff, lft_ff;
   rsp_type        rsp_ff;

   logic [AW-1:0]  par_idx, rd_addr;
   logic [CIW-1:0] lft_idx, rgt_idx, pick_idx;
   logic           l_ok, r_ok, r_less, wr_en;
   logic [63:0]    pick_ent, wr_data;

   assign par_idx = (idx_ff - AW'(1)) >> 1;
   assign lft_idx = {1'b0, idx_ff, 1'b1};
   assign rgt_idx = lft_idx + CIW'(1);
   assign l_ok    = lft_idx < CIW'(count_ff);
   assign r_ok    = rgt_idx < CIW'(count_ff);

   // smaller live child; a tie keeps the left one
   always_comb begin
      r_less   = r_ok && (rd_ff[63:32] < lft_ff[63:32]);
      pick_ent = r_less ? rd_ff : lft_ff;
      pick_idx = r_less ? rgt_idx : lft_idx;
   end

   always_comb begin
      rd_addr = idx_ff;
      if (cmd.rd_par)   rd_addr = par_idx;
      if (cmd.rd_left)  rd_addr = lft_idx[AW-1:0];
      if (cmd.rd_right) rd_addr = rgt_idx[AW-1:0];
      if (cmd.rd_top)   rd_addr = '0;
   end

   // the index always holds the hole left by the moving entry
   always_comb begin
      wr_en   = cmd.place | cmd.move_up | cmd.move_down;
      wr_data = cur_ff;
      if (cmd.move_up)   wr_data = rd_ff;
      if (cmd.move_down) wr_data = pick_ent;
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (wr_en) mem[idx_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.grow) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_in;
         if (req_in.mode == MODE_INSERT) idx_ff <= AW'(count_ff);
         else                            idx_ff <= AW'(req_in.position);
      end
      if (cmd.move_up)   idx_ff <= par_idx;
      if (cmd.move_down) idx_ff <= pick_idx[AW-1:0];
      if (cmd.start) begin
         case (req_ff.mode)
            MODE_INSERT:   cur_ff <= {req_ff.entry_key, req_ff.entry_value};
            MODE_DECREASE: cur_ff <= {req_ff.entry_key, rd_ff[31:0]};
            default:       cur_ff <= rd_ff;
         endcase
      end
      if (cmd.rd_right) lft_ff <= rd_ff;
      if (cmd.finish) begin
         rsp_ff.status      <= cmd.status;
         rsp_ff.entry_count <= COUNT_W'(count_ff);
         if (count_ff == '0) begin
            rsp_ff.top_key   <= '0;
            rsp_ff.top_value <= '0;
         end else begin
            rsp_ff.top_key   <= rd_ff[63:32];
            rsp_ff.top_value <= rd_ff[31:0];
         end
      end
   end

   always_comb begin
      sts.mode        = req_ff.mode;
      sts.full        = count_ff >= CW'(CAPACITY);
      sts.not_live    = PW'(req_ff.position) >= PW'(count_ff);
      sts.not_lowered = req_ff.entry_key > rd_ff[63:32];
      sts.at_root     = idx_ff == '0;
      sts.up_move     = cur_ff[63:32] < rd_ff[63:32];
      sts.has_left    = l_ok;
      sts.down_move   = pick_ent[63:32] < cur_ff[63:32];
   end

   assign rsp_out = rsp_ff;
endmodule

// ===== design/bmh_ctrl.sv =====
// Controller for the binary min-heap: sequences each request through
// reads, compares and moves. Depends on bmh_pkg.
module bmh_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  bmh_pkg::sts_type sts,
   output bmh_pkg::cmd_type cmd
);
   import bmh_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_CHECK, S_UP_RD, S_UP_CMP, S_DN_LEFT, S_DN_RIGHT,
      S_DN_CMP, S_PLACE, S_TOP, S_FIN, S_OUT
   } state_type;

   state_type  state_ff;
   logic [1:0] status_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      cmd = '0;
      cmd.status = status_ff;
      case (state_ff)
         S_IDLE:  cmd.load = req_valid;
         S_CHECK: begin
            case (sts.mode)
               MODE_INSERT: begin
                  cmd.start = !sts.full;
                  cmd.grow  = !sts.full;
               end
               MODE_DECREASE: cmd.start = !sts.not_live && !sts.not_lowered;
               MODE_SINK:     cmd.start = !sts.not_live;
               default: ;
            endcase
         end
         S_UP_RD:    cmd.rd_par    = !sts.at_root;
         S_UP_CMP:   cmd.move_up   = sts.up_move;
         S_DN_LEFT:  cmd.rd_left   = sts.has_left;
         S_DN_RIGHT: cmd.rd_right  = 1'b1;
         S_DN_CMP:   cmd.move_down = sts.down_move;
         S_PLACE:    cmd.place     = 1'b1;
         S_TOP:      cmd.rd_top    = 1'b1;
         S_FIN:      cmd.finish    = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_LOAD;
            S_LOAD: state_ff <= S_CHECK;
            S_CHECK: begin
               status_ff <= ST_OK;
               state_ff  <= S_TOP;
               case (sts.mode)
                  MODE_INSERT: begin
                     if (sts.full) status_ff <= ST_FULL;
                     else          state_ff  <= S_UP_RD;
                  end
                  MODE_DECREASE: begin
                     if (sts.not_live)         status_ff <= ST_NOT_LIVE;
                     else if (sts.not_lowered) status_ff <= ST_NOT_LOWERED;
                     else                      state_ff  <= S_UP_RD;
                  end
                  MODE_SINK: begin
                     if (sts.not_live) status_ff <= ST_NOT_LIVE;
                     else              state_ff  <= S_DN_LEFT;
                  end
                  default: ;
               endcase
            end
            S_UP_RD:    state_ff <= sts.at_root ? S_PLACE : S_UP_CMP;
            S_UP_CMP:   state_ff <= sts.up_move ? S_UP_RD : S_PLACE;
            S_DN_LEFT:  state_ff <= sts.has_left ? S_DN_RIGHT : S_PLACE;
            S_DN_RIGHT: state_ff <= S_DN_CMP;
            S_DN_CMP:   state_ff <= sts.down_move ? S_DN_LEFT : S_PLACE;
            S_PLACE:    state_ff <= S_TOP;
            S_TOP:      state_ff <= S_FIN;
            S_FIN:      state_ff <= S_OUT;
            S_OUT:      if (rsp_ready) state_ff <= S_IDLE;
            default:    state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== design/binary_min_heap.sv =====
// Binary min-heap priority queue of key/value entries, CAPACITY deep
// (default 64). One request at a time: insert (append and sift up),
// decrease key at a position (sift up), or sift down from a position.
// Each request gives one response with status, root key/value and live
// count; an empty heap reports a zero root. The entry memory has one read
// and one write a cycle, and the moving entry rides in a hold register
// until its final slot is known. A rejected request or an unused mode goes
// from the check straight to the root read and the response; an accepted
// request first sifts, climbing with a parent read and compare per level
// or descending with left read, right read and compare per level, then
// places the held entry. The entry memory needs no clearing after reset.
// Depends on bmh_pkg, bmh_ctrl and bmh_datapath.
module binary_min_heap #(
   parameter int unsigned CAPACITY = bmh_pkg::DEF_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bmh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bmh_pkg::rsp_type rsp_data
);
   import bmh_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence each request
   bmh_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   // hold entries, compute compares and the response
   bmh_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock, .reset, .req_in(req_data), .cmd, .sts, .rsp_out(rsp_data)
   );
endmodule

// ===== design/bmh_checker.sv =====
// Port-level checks for the binary min-heap, bound to the top level.
// Depends on bmh_pkg.
module bmh_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bmh_pkg::rsp_type rsp_data
);
   import bmh_pkg::*;

   // one request in flight: no acceptance while a response waits
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while busy");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // empty heap reports zero root
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_count == '0 |-> rsp_data.top_key == '0)
      else $error("empty heap root not zero");

   // count never exceeds the default capacity
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= COUNT_W'(DEF_CAPACITY))
      else $error("count above capacity");
endmodule

bind binary_min_heap bmh_checker u_bmh_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
